@@ rtl/rbc_pkg.sv @@
// Package for the Raiden block cipher unit: constants, register and mode codes,
// the configuration struct and the round mix function. No dependencies.
`default_nettype none

package rbc_pkg;

    localparam int RBC_ROUNDS  = 16;
    localparam int RBC_WORD_W  = 32;
    localparam int RBC_PADDR_W = 5;
    localparam int RBC_SHL     = 9;
    localparam int RBC_SHR     = 14;
    localparam logic [4:0] RBC_SHAMT_MASK = 5'h1F;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_KEY0    = 3'd0;
    localparam logic [2:0] REG_KEY1    = 3'd1;
    localparam logic [2:0] REG_KEY2    = 3'd2;
    localparam logic [2:0] REG_KEY3    = 3'd3;
    localparam logic [2:0] REG_IV_LOW  = 3'd4;
    localparam logic [2:0] REG_IV_HIGH = 3'd5;
    localparam logic [2:0] REG_MODE    = 3'd6;
    localparam logic [2:0] REG_DIR     = 3'd7;

    // chaining modes; codes above OFB behave as ECB
    localparam logic [2:0] MODE_ECB  = 3'd0;
    localparam logic [2:0] MODE_CBC  = 3'd1;
    localparam logic [2:0] MODE_PCBC = 3'd2;
    localparam logic [2:0] MODE_CFB  = 3'd3;
    localparam logic [2:0] MODE_OFB  = 3'd4;

    typedef logic [RBC_WORD_W-1:0] t_word;

    typedef struct packed {
        t_word [3:0] key;
        t_word       iv_low;
        t_word       iv_high;
        logic [2:0]  mode;
        logic        dec;
    } t_cfg;

    function automatic t_word rbc_mix(input t_word k, input t_word v);
        t_word s;
        s = k + v;
        return (s << RBC_SHL) ^ ((k - v) ^ (s >> RBC_SHR));
    endfunction

endpackage

`default_nettype wire

@@ rtl/rbc_in_if.sv @@
// Input block channel: valid/ready plus one 64-bit block and framing flags.
// Depends on rbc_pkg.
`default_nettype none

interface rbc_in_if;
    import rbc_pkg::*;

    logic  valid;
    logic  ready;
    t_word data_low;
    t_word data_high;
    logic  first_block;
    logic  last_block;

    modport source (output valid, output data_low, output data_high,
                    output first_block, output last_block, input ready);
    modport sink   (input valid, input data_low, input data_high,
                    input first_block, input last_block, output ready);
endinterface

`default_nettype wire

@@ rtl/rbc_out_if.sv @@
// Result block channel: valid/ready plus one 64-bit result and end flag.
// Depends on rbc_pkg.
`default_nettype none

interface rbc_out_if;
    import rbc_pkg::*;

    logic  valid;
    logic  ready;
    t_word result_low;
    t_word result_high;
    logic  end_of_message;

    modport source (output valid, output result_low, output result_high,
                    output end_of_message, input ready);
    modport sink   (input valid, input result_low, input result_high,
                    input end_of_message, output ready);
endinterface

`default_nettype wire

@@ rtl/rbc_cfg_regs.sv @@
// APB-style register file for key, IV, mode and direction.
// Depends on rbc_pkg.
`default_nettype none

module rbc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rbc_pkg::RBC_PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    output rbc_pkg::t_cfg                         o_cfg,
    output logic                                  o_key_wr
);
    import rbc_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[RBC_PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_KEY0:    r_cfg.key[0]  <= pwdata;
                REG_KEY1:    r_cfg.key[1]  <= pwdata;
                REG_KEY2:    r_cfg.key[2]  <= pwdata;
                REG_KEY3:    r_cfg.key[3]  <= pwdata;
                REG_IV_LOW:  r_cfg.iv_low  <= pwdata;
                REG_IV_HIGH: r_cfg.iv_high <= pwdata;
                REG_MODE:    r_cfg.mode    <= pwdata[2:0];
                REG_DIR:     r_cfg.dec     <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_KEY0:    prdata = r_cfg.key[0];
            REG_KEY1:    prdata = r_cfg.key[1];
            REG_KEY2:    prdata = r_cfg.key[2];
            REG_KEY3:    prdata = r_cfg.key[3];
            REG_IV_LOW:  prdata = r_cfg.iv_low;
            REG_IV_HIGH: prdata = r_cfg.iv_high;
            REG_MODE:    prdata = {29'd0, r_cfg.mode};
            REG_DIR:     prdata = {31'd0, r_cfg.dec};
            default:     prdata = '0;
        endcase
    end

    // any key word write invalidates the subkey table
    assign o_key_wr = wr_en && (idx == REG_KEY0 || idx == REG_KEY1 ||
                                idx == REG_KEY2 || idx == REG_KEY3);
    assign o_cfg    = r_cfg;

endmodule

`default_nettype wire

@@ rtl/rbc_subkey_ram.sv @@
// Subkey table: one write port, one read port, registered read data.
// Depends on rbc_pkg.
`default_nettype none

module rbc_subkey_ram #(
    parameter int DEPTH = rbc_pkg::RBC_ROUNDS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire rbc_pkg::t_word i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output rbc_pkg::t_word     o_rdata
);
    import rbc_pkg::*;

    t_word r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/rbc_key_sched.sv @@
// Key schedule sequencer: one subkey per cycle into the subkey table,
// rerun after reset and after every key write. Depends on rbc_pkg.
`default_nettype none

module rbc_key_sched #(
    parameter int ROUNDS = rbc_pkg::RBC_ROUNDS,
    parameter int AW     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rbc_pkg::t_cfg i_cfg,
    input  wire logic          i_key_wr,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output rbc_pkg::t_word     o_wdata,
    output logic               o_ready
);
    import rbc_pkg::*;

    typedef enum logic [1:0] {KS_LOAD, KS_RUN, KS_SETTLE, KS_IDLE} t_ks_state;

    t_ks_state       r_state;
    logic [AW-1:0]   r_cnt;
    logic [1:0]      r_mptr;
    t_word [3:0]     r_m;
    t_word           n_sub;

    assign n_sub = (r_m[0] + r_m[1]) +
                   ((r_m[2] + r_m[3]) ^ (r_m[0] << (r_m[2][4:0] & RBC_SHAMT_MASK)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_LOAD;
            r_cnt   <= '0;
            r_mptr  <= '0;
        end else if (i_key_wr) begin
            r_state <= KS_LOAD;
        end else begin
            unique case (r_state)
                KS_LOAD: begin
                    r_m     <= i_cfg.key;
                    r_cnt   <= '0;
                    r_mptr  <= '0;
                    r_state <= KS_RUN;
                end
                KS_RUN: begin
                    r_m[r_mptr] <= n_sub;
                    r_mptr      <= r_mptr + 2'd1;
                    r_cnt       <= r_cnt + AW'(1);
                    if (r_cnt == AW'(ROUNDS - 1)) begin
                        r_state <= KS_SETTLE;
                    end
                end
                // table read port catches up with the last write
                KS_SETTLE: r_state <= KS_IDLE;
                KS_IDLE:   r_state <= KS_IDLE;
                default:   r_state <= KS_LOAD;
            endcase
        end
    end

    assign o_we    = (r_state == KS_RUN);
    assign o_waddr = r_cnt;
    assign o_wdata = n_sub;
    assign o_ready = (r_state == KS_IDLE);

endmodule

`default_nettype wire

@@ rtl/rbc_cipher_core.sv @@
// Round engine and chaining logic: reads subkeys from the table one per
// round, holds the chaining vector and the result register. Depends on rbc_pkg.
`default_nettype none

module rbc_cipher_core #(
    parameter int ROUNDS = rbc_pkg::RBC_ROUNDS,
    parameter int AW     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rbc_pkg::t_cfg  i_cfg,
    input  wire logic           i_ks_ready,
    output logic [AW-1:0]       o_raddr,
    input  wire rbc_pkg::t_word i_rdata,
    rbc_in_if.sink              i_blk,
    rbc_out_if.source           o_res
);
    import rbc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_DONE} t_state;

    localparam logic [AW-1:0] LAST = AW'(ROUNDS - 1);

    t_state        r_state;
    logic [AW-1:0] r_cnt;
    t_word         r_a, r_b;
    logic [63:0]   r_p;
    logic          r_last;
    logic [63:0]   r_chain;
    logic          r_out_valid;
    t_word         r_out_low, r_out_high;
    logic          r_out_eom;

    logic          use_inv, out_free, acc, ready;
    logic [63:0]   p_in, iv, chain_src, chain_in, x_in;
    logic [63:0]   y, n_out, n_chain;
    t_word         n_a, n_b, m1, m2;
    logic [AW-1:0] start_idx, next_k;

    // CFB and OFB always run the forward cipher
    assign use_inv   = i_cfg.dec && i_cfg.mode != MODE_CFB && i_cfg.mode != MODE_OFB;
    assign start_idx = use_inv ? LAST : '0;
    assign next_k    = r_cnt + AW'(1);

    // table address: prefetch the next round's subkey, else park on the first one
    always_comb begin
        if (r_state == ST_ROUND && r_cnt != LAST) begin
            o_raddr = use_inv ? (LAST - next_k) : next_k;
        end else begin
            o_raddr = start_idx;
        end
    end

    // one full round per cycle
    always_comb begin
        if (use_inv) begin
            m1  = rbc_mix(i_rdata, r_a);
            n_b = r_b - m1;
            m2  = rbc_mix(i_rdata, n_b);
            n_a = r_a - m2;
        end else begin
            m1  = rbc_mix(i_rdata, r_b);
            n_a = r_a + m1;
            m2  = rbc_mix(i_rdata, n_a);
            n_b = r_b + m2;
        end
    end

    // chaining on the finished block
    assign y = {r_b, r_a};
    always_comb begin
        n_chain = r_chain;
        case (i_cfg.mode)
            MODE_CBC: begin
                n_out   = i_cfg.dec ? (y ^ r_chain) : y;
                n_chain = i_cfg.dec ? r_p : n_out;
            end
            MODE_PCBC: begin
                n_out   = i_cfg.dec ? (y ^ r_chain) : y;
                n_chain = n_out ^ r_p;
            end
            MODE_CFB: begin
                n_out   = r_p ^ y;
                n_chain = i_cfg.dec ? r_p : n_out;
            end
            MODE_OFB: begin
                n_out   = r_p ^ y;
                n_chain = y;
            end
            default: n_out = y;
        endcase
    end

    assign out_free = !r_out_valid || o_res.ready;
    assign ready    = i_ks_ready &&
                      (r_state == ST_IDLE || (r_state == ST_DONE && out_free));
    assign acc      = i_blk.valid && ready;

    // forward the chain being written back by the block that finishes now
    assign p_in      = {i_blk.data_high, i_blk.data_low};
    assign iv        = {i_cfg.iv_high, i_cfg.iv_low};
    assign chain_src = (r_state == ST_DONE) ? n_chain : r_chain;
    assign chain_in  = i_blk.first_block ? iv : chain_src;

    always_comb begin
        case (i_cfg.mode) inside
            MODE_CBC, MODE_PCBC: x_in = i_cfg.dec ? p_in : (p_in ^ chain_in);
            MODE_CFB, MODE_OFB:  x_in = chain_in;
            default:             x_in = p_in;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_chain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: ;
                ST_ROUND: begin
                    r_a   <= n_a;
                    r_b   <= n_b;
                    r_cnt <= next_k;
                    if (r_cnt == LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_low   <= n_out[31:0];
                        r_out_high  <= n_out[63:32];
                        r_out_eom   <= r_last;
                        r_chain     <= n_chain;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (acc) begin
                r_a     <= x_in[31:0];
                r_b     <= x_in[63:32];
                r_p     <= p_in;
                r_last  <= i_blk.last_block;
                r_chain <= chain_in;
                r_cnt   <= '0;
                r_state <= ST_ROUND;
            end
        end
    end

    assign i_blk.ready          = ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.result_low     = r_out_low;
    assign o_res.result_high    = r_out_high;
    assign o_res.end_of_message = r_out_eom;

    a_round_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_cnt != LAST) |=>
        (r_state == ST_ROUND && r_cnt == $past(next_k)))
        else $error("round counter skipped or left the round loop early");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside the finish step");

    a_no_accept_in_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> !i_blk.ready)
        else $error("input taken while rounds are running");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !out_free) |=> (r_state == ST_DONE))
        else $error("finished block dropped while result register full");

endmodule

`default_nettype wire

@@ rtl/raiden_block_cipher_modes.sv @@
// Raiden 64-bit block cipher, 128-bit key, ECB/CBC/PCBC/CFB/OFB chaining.
// Blocks run the round loop, then the finish step loads the result register.
// A new block is taken only when the core is idle or the last is in the finish
// step with the result register free. The round loop reads one subkey per cycle
// from the subkey table's single read port. Reset clears the registers and chain;
// the key schedule fills the table, input held off, and reruns on any key write.
`default_nettype none

module raiden_block_cipher_modes #(
    parameter int ROUNDS = rbc_pkg::RBC_ROUNDS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rbc_pkg::RBC_PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    rbc_in_if.sink                                i_blk,
    rbc_out_if.source                             o_res
);
    import rbc_pkg::*;

    // subkey table address width
    localparam int AW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    t_cfg          cfg;
    logic          key_wr;
    logic          ks_we, ks_ready;
    logic [AW-1:0] ks_waddr, sk_raddr;
    t_word         ks_wdata, sk_rdata;

    // register file; key writes restart the schedule
    rbc_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_key_wr (key_wr)
    );

    // key expansion, one subkey per cycle into the table
    rbc_key_sched #(.ROUNDS(ROUNDS), .AW(AW)) u_ks (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_key_wr (key_wr),
        .o_we     (ks_we),
        .o_waddr  (ks_waddr),
        .o_wdata  (ks_wdata),
        .o_ready  (ks_ready)
    );

    // subkey table, read in forward or reverse order by the round engine
    rbc_subkey_ram #(.DEPTH(ROUNDS), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ks_we),
        .i_waddr (ks_waddr),
        .i_wdata (ks_wdata),
        .i_raddr (sk_raddr),
        .o_rdata (sk_rdata)
    );

    // rounds, chaining vector and result register
    rbc_cipher_core #(.ROUNDS(ROUNDS), .AW(AW)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_ks_ready (ks_ready),
        .o_raddr    (sk_raddr),
        .i_rdata    (sk_rdata),
        .i_blk      (i_blk),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire
